@@ design/dmc_pkg.sv @@
`default_nettype none
package dmc_pkg;

    localparam int ADDR_W         = 12;
    localparam int DATA_W         = 32;
    localparam int LINES          = 64;
    localparam int WORDS_PER_LINE = 4;
    localparam int MEMORY_BLOCKS  = 1024;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic
    {
        ACC_READ  = 1'b0,
        ACC_WRITE = 1'b1
    } access_t;

    typedef enum logic
    {
        CFG_WRITE_THROUGH     = 1'b0,
        CFG_NO_WRITE_ALLOCATE = 1'b1
    } cfg_index_t;

    typedef struct packed
    {
        logic write_through;
        logic no_write_allocate;
    } cfg_t;

    typedef struct packed
    {
        access_t             kind;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   data;
    } req_t;

    typedef enum logic [2:0]
    {
        S_CLR,
        S_IDLE,
        S_LOOK,
        S_DEC,
        S_EVICT,
        S_FILL,
        S_RES
    } state_t;

endpackage
`default_nettype wire

@@ design/dmc_front.sv @@
`default_nettype none
module dmc_front
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [47:0]                s_tdata,
    input  wire logic                       s_tuser,
    input  wire logic                       accept_en,
    output logic                            q_valid,
    output dmc_pkg::req_t                   q_item,
    input  wire logic                       q_pop
);

    localparam int PTR_W = $clog2(dmc_pkg::QUEUE_DEPTH);

    dmc_pkg::req_t    ent_reg [dmc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             push;
    dmc_pkg::req_t    item;

    always_comb
    begin
        item.kind = s_tuser ? dmc_pkg::ACC_WRITE : dmc_pkg::ACC_READ;
        item.addr = s_tdata[dmc_pkg::ADDR_W-1:0];
        item.data = s_tdata[dmc_pkg::ADDR_W+dmc_pkg::DATA_W-1:dmc_pkg::ADDR_W];
    end

    assign s_tready = accept_en && (count_reg != (PTR_W+1)'(dmc_pkg::QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ design/dmc_back.sv @@
`default_nettype none
module dmc_back
#(
    parameter int LINES          = dmc_pkg::LINES,
    parameter int WORDS_PER_LINE = dmc_pkg::WORDS_PER_LINE,
    parameter int MEMORY_BLOCKS  = dmc_pkg::MEMORY_BLOCKS
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dmc_pkg::cfg_t              cfg,
    input  wire logic                       q_valid,
    input  wire dmc_pkg::req_t              q_item,
    output logic                            q_pop,
    output logic                            accept_en,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [31:0]                     m_tdata,
    output logic                            m_tuser
);

    localparam int OFF_W     = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
    localparam int IDX_W     = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int TAGS      = (MEMORY_BLOCKS + LINES - 1) / LINES;
    localparam int TAG_W     = (TAGS > 1) ? $clog2(TAGS) : 1;
    localparam int MEM_DEPTH = MEMORY_BLOCKS * WORDS_PER_LINE;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int LW_DEPTH  = LINES * WORDS_PER_LINE;
    localparam int LW_AW     = (LW_DEPTH > 1) ? $clog2(LW_DEPTH) : 1;
    localparam int CNT_W     = $clog2(WORDS_PER_LINE + 1);
    localparam int DW        = dmc_pkg::DATA_W;

    logic [TAG_W-1:0]  tag_mem  [LINES];
    logic [DW-1:0]     words_mem[LW_DEPTH];
    logic [DW-1:0]     back_mem [MEM_DEPTH];
    logic [TAG_W-1:0]  tag_q;
    logic [DW-1:0]     words_q;
    logic [DW-1:0]     back_q;

    dmc_pkg::state_t   state_reg, state_next;
    dmc_pkg::access_t  op_reg, op_next;
    logic [DW-1:0]     data_reg, data_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [MEM_AW-1:0] mpos_reg, mpos_next;
    logic [MEM_AW-1:0] bbase_reg, bbase_next;
    logic [MEM_AW-1:0] vbase_reg, vbase_next;
    logic [MEM_AW-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              hit_reg, hit_next;
    logic [DW-1:0]     rdata_reg, rdata_next;
    logic [LINES-1:0]  valid_reg, valid_next;
    logic [LINES-1:0]  dirty_reg, dirty_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DW-1:0]     m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;

    logic              tg_we;
    logic              w_we;
    logic [LW_AW-1:0]  w_wa;
    logic [LW_AW-1:0]  w_ra;
    logic [DW-1:0]     w_wd;
    logic              b_we;
    logic [MEM_AW-1:0] b_wa;
    logic [MEM_AW-1:0] b_ra;
    logic [DW-1:0]     b_wd;
    logic              hit_c;
    logic              miss_go;
    logic              at_off;
    logic [LW_AW-1:0]  line_pos;
    logic [LW_AW-1:0]  line_cnt;
    logic [LW_AW-1:0]  line_prev;
    int                blk_i;

    assign accept_en = (state_reg != dmc_pkg::S_CLR);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign hit_c     = valid_reg[idx_reg] && (tag_q == tag_reg);
    assign line_pos  = LW_AW'(int'(idx_reg) * WORDS_PER_LINE + int'(off_reg));
    assign line_cnt  = LW_AW'(int'(idx_reg) * WORDS_PER_LINE + int'(cnt_reg));
    assign line_prev = LW_AW'(int'(idx_reg) * WORDS_PER_LINE + int'(cnt_reg) - 1);
    assign at_off    = (int'(cnt_reg) - 1 == int'(off_reg));

    always_ff @(posedge clk)
    begin
        if (tg_we)
        begin
            tag_mem[idx_reg] <= tag_reg;
        end
        tag_q <= tag_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            words_mem[w_wa] <= w_wd;
        end
        words_q <= words_mem[w_ra];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            back_mem[b_wa] <= b_wd;
        end
        back_q <= back_mem[b_ra];
    end

    always_comb
    begin
        blk_i = (int'(q_item.addr) / WORDS_PER_LINE) % MEMORY_BLOCKS;

        state_next    = state_reg;
        op_next       = op_reg;
        data_next     = data_reg;
        off_next      = off_reg;
        idx_next      = idx_reg;
        tag_next      = tag_reg;
        mpos_next     = mpos_reg;
        bbase_next    = bbase_reg;
        vbase_next    = vbase_reg;
        clr_next      = clr_reg;
        cnt_next      = cnt_reg;
        hit_next      = hit_reg;
        rdata_next    = rdata_reg;
        valid_next    = valid_reg;
        dirty_next    = dirty_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        q_pop   = 1'b0;
        tg_we   = 1'b0;
        w_we    = 1'b0;
        w_wa    = line_pos;
        w_ra    = line_pos;
        w_wd    = data_reg;
        b_we    = 1'b0;
        b_wa    = mpos_reg;
        b_ra    = MEM_AW'(int'(bbase_reg) + int'(cnt_reg));
        b_wd    = data_reg;
        miss_go = 1'b0;

        case (state_reg)
            dmc_pkg::S_CLR:
            begin
                b_we = 1'b1;
                b_wa = clr_reg;
                b_wd = '0;
                if (int'(clr_reg) == MEM_DEPTH - 1)
                begin
                    state_next = dmc_pkg::S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            dmc_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    op_next    = q_item.kind;
                    data_next  = q_item.data;
                    off_next   = OFF_W'(int'(q_item.addr) % WORDS_PER_LINE);
                    idx_next   = IDX_W'(blk_i % LINES);
                    tag_next   = TAG_W'(blk_i / LINES);
                    bbase_next = MEM_AW'(blk_i * WORDS_PER_LINE);
                    mpos_next  = MEM_AW'(blk_i * WORDS_PER_LINE
                                         + int'(q_item.addr) % WORDS_PER_LINE);
                    state_next = dmc_pkg::S_LOOK;
                end
            end
            dmc_pkg::S_LOOK:
            begin
                state_next = dmc_pkg::S_DEC;
            end
            dmc_pkg::S_DEC:
            begin
                hit_next   = hit_c;
                rdata_next = '0;
                cnt_next   = '0;
                vbase_next = MEM_AW'((int'(tag_q) * LINES + int'(idx_reg)) * WORDS_PER_LINE);
                state_next = dmc_pkg::S_RES;
                if (op_reg == dmc_pkg::ACC_READ)
                begin
                    if (hit_c)
                    begin
                        rdata_next = words_q;
                    end
                    else
                    begin
                        miss_go = 1'b1;
                    end
                end
                else if (cfg.write_through)
                begin
                    b_we = 1'b1;
                    if (hit_c)
                    begin
                        w_we = 1'b1;
                    end
                    else if (!cfg.no_write_allocate)
                    begin
                        miss_go = 1'b1;
                    end
                end
                else
                begin
                    if (hit_c)
                    begin
                        w_we                = 1'b1;
                        dirty_next[idx_reg] = 1'b1;
                    end
                    else if (!cfg.no_write_allocate)
                    begin
                        miss_go = 1'b1;
                    end
                    else
                    begin
                        b_we = 1'b1;
                    end
                end
                if (miss_go)
                begin
                    state_next = (valid_reg[idx_reg] && dirty_reg[idx_reg])
                                 ? dmc_pkg::S_EVICT : dmc_pkg::S_FILL;
                end
            end
            dmc_pkg::S_EVICT:
            begin
                w_ra = line_cnt;
                if (cnt_reg != '0)
                begin
                    b_we = 1'b1;
                    b_wa = MEM_AW'(int'(vbase_reg) + int'(cnt_reg) - 1);
                    b_wd = words_q;
                end
                if (int'(cnt_reg) == WORDS_PER_LINE)
                begin
                    cnt_next   = '0;
                    state_next = dmc_pkg::S_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            dmc_pkg::S_FILL:
            begin
                if (cnt_reg != '0)
                begin
                    w_we = 1'b1;
                    w_wa = line_prev;
                    w_wd = back_q;
                    if (at_off && op_reg == dmc_pkg::ACC_WRITE && !cfg.write_through)
                    begin
                        w_wd = data_reg;
                    end
                    if (at_off && op_reg == dmc_pkg::ACC_READ)
                    begin
                        rdata_next = back_q;
                    end
                end
                if (int'(cnt_reg) == WORDS_PER_LINE)
                begin
                    tg_we               = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    dirty_next[idx_reg] = (op_reg == dmc_pkg::ACC_WRITE) && !cfg.write_through;
                    state_next          = dmc_pkg::S_RES;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            dmc_pkg::S_RES:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rdata_reg;
                    m_tuser_next  = hit_reg;
                    state_next    = dmc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dmc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dmc_pkg::S_CLR;
            clr_reg      <= '0;
            cnt_reg      <= '0;
            valid_reg    <= '0;
            dirty_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            cnt_reg      <= cnt_next;
            valid_reg    <= valid_next;
            dirty_reg    <= dirty_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        data_reg    <= data_next;
        off_reg     <= off_next;
        idx_reg     <= idx_next;
        tag_reg     <= tag_next;
        mpos_reg    <= mpos_next;
        bbase_reg   <= bbase_next;
        vbase_reg   <= vbase_next;
        hit_reg     <= hit_next;
        rdata_reg   <= rdata_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid && state_reg == dmc_pkg::S_IDLE)
        else $error("pop without a queued beat");

    a_pop_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == dmc_pkg::S_LOOK)
        else $error("lookup did not follow pop");

    a_evict_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dmc_pkg::S_EVICT |-> valid_reg[idx_reg] && dirty_reg[idx_reg])
        else $error("eviction of a clean line");
`endif

endmodule
`default_nettype wire

@@ design/direct_mapped_cache_unit.sv @@
`default_nettype none
// Direct-mapped cache over a word-addressed backing memory, one read or write per s_ beat and
// one m_ beat back (read word, hit flag). After reset a clearing pass zeroes all of the backing
// memory, MEMORY_BLOCKS*WORDS_PER_LINE words (4096 by default), during which s_tready stays low.
// A hit passes through the controller's dequeue, lookup, decide and result states; a miss that
// allocates adds a refill of the line, and a dirty miss a write-back of the old line before it.
// A two-beat queue in front lets the input run ahead of the controller.
module direct_mapped_cache_unit
#(
    parameter int LINES          = dmc_pkg::LINES,
    parameter int WORDS_PER_LINE = dmc_pkg::WORDS_PER_LINE,
    parameter int MEMORY_BLOCKS  = dmc_pkg::MEMORY_BLOCKS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // word_address[11:0], write_data[43:12], zero fill
    input  wire logic        s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // read_data[31:0]
    output logic             m_tuser,   // hit
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [0:0]  cfg_data
);

    dmc_pkg::cfg_t cfg_reg;
    dmc_pkg::req_t q_item;
    logic          q_valid;
    logic          q_pop;
    logic          accept_en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (dmc_pkg::cfg_index_t'(cfg_index))
                dmc_pkg::CFG_WRITE_THROUGH:     cfg_reg.write_through     <= cfg_data[0];
                dmc_pkg::CFG_NO_WRITE_ALLOCATE: cfg_reg.no_write_allocate <= cfg_data[0];
                default:                        cfg_reg <= cfg_reg;
            endcase
        end
    end

    dmc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .accept_en (accept_en),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    dmc_back
    #(
        .LINES          (LINES),
        .WORDS_PER_LINE (WORDS_PER_LINE),
        .MEMORY_BLOCKS  (MEMORY_BLOCKS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .accept_en (accept_en),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

@@ verif/direct_mapped_cache_unit_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module direct_mapped_cache_unit_tb;

    typedef struct packed
    {
        logic [31:0] rdata;
        logic        hit;
    } access_result_t;

    class cache_scoreboard;
        bit             wt;
        bit             nwa;
        bit             valid_q [dmc_pkg::LINES];
        bit             dirty_q [dmc_pkg::LINES];
        logic [3:0]     tag_q   [dmc_pkg::LINES];
        logic [31:0]    words_q [dmc_pkg::LINES*dmc_pkg::WORDS_PER_LINE];
        logic [31:0]    mem_q   [dmc_pkg::MEMORY_BLOCKS*dmc_pkg::WORDS_PER_LINE];
        access_result_t pending [$];
        int             errors;

        function new();
            foreach (valid_q[i])
            begin
                valid_q[i] = 0;
                dirty_q[i] = 0;
                tag_q[i]   = '0;
            end
            foreach (words_q[i])
                words_q[i] = '0;
            foreach (mem_q[i])
                mem_q[i] = '0;
            wt     = 0;
            nwa    = 0;
            errors = 0;
        endfunction

        function void load_line(int idx, int blk, logic [3:0] tg);
            int victim;
            if (valid_q[idx] && dirty_q[idx])
            begin
                victim = (tag_q[idx] * dmc_pkg::LINES + idx) % dmc_pkg::MEMORY_BLOCKS;
                for (int i = 0; i < dmc_pkg::WORDS_PER_LINE; i++)
                    mem_q[victim*dmc_pkg::WORDS_PER_LINE+i] =
                        words_q[idx*dmc_pkg::WORDS_PER_LINE+i];
            end
            for (int i = 0; i < dmc_pkg::WORDS_PER_LINE; i++)
                words_q[idx*dmc_pkg::WORDS_PER_LINE+i] = mem_q[blk*dmc_pkg::WORDS_PER_LINE+i];
            tag_q[idx]   = tg;
            valid_q[idx] = 1;
            dirty_q[idx] = 0;
        endfunction

        function void note_access(dmc_pkg::access_t kind, logic [11:0] addr,
                                  logic [31:0] data);
            int             blk;
            int             off;
            int             idx;
            logic [3:0]     tg;
            int             lp;
            int             mp;
            access_result_t r;
            blk = (addr / dmc_pkg::WORDS_PER_LINE) % dmc_pkg::MEMORY_BLOCKS;
            off = addr % dmc_pkg::WORDS_PER_LINE;
            idx = blk % dmc_pkg::LINES;
            tg  = 4'(blk / dmc_pkg::LINES);
            lp  = idx*dmc_pkg::WORDS_PER_LINE + off;
            mp  = blk*dmc_pkg::WORDS_PER_LINE + off;
            r.hit   = valid_q[idx] && tag_q[idx] == tg;
            r.rdata = '0;
            if (kind == dmc_pkg::ACC_READ)
            begin
                if (!r.hit)
                    load_line(idx, blk, tg);
                r.rdata = words_q[lp];
            end
            else if (wt)
            begin
                mem_q[mp] = data;
                if (r.hit)
                    words_q[lp] = data;
                else if (!nwa)
                    load_line(idx, blk, tg);
            end
            else if (r.hit)
            begin
                words_q[lp]  = data;
                dirty_q[idx] = 1;
            end
            else if (!nwa)
            begin
                load_line(idx, blk, tg);
                words_q[lp]  = data;
                dirty_q[idx] = 1;
            end
            else
                mem_q[mp] = data;
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(logic [31:0] rdata, logic hit);
            access_result_t e;
            if (pending.size() == 0)
            begin
                report("unexpected result beat");
                return;
            end
            e = pending.pop_front();
            if (rdata !== e.rdata)
                report($sformatf("read_data %h, want %h", rdata, e.rdata));
            if (hit !== e.hit)
                report($sformatf("hit %b, want %b", hit, e.hit));
        endfunction

        function void report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [0:0]  cfg_data;

    cache_scoreboard sb;
    longint          cycles;
    int              hold_off;
    bit              finished;

    direct_mapped_cache_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
        clk = 0;
    always #1 clk = ~clk;

    function int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 0;
        else if (hold_off > 0)
        begin
            m_tready <= 0;
            hold_off <= hold_off - 1;
        end
        else
            m_tready <= ($urandom_range(0, 99) < 70);
    end

    initial
    begin
        while (cycles < 3000000 && !finished)
            @(posedge clk);
        if (!finished)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_access(dmc_pkg::access_t kind, logic [11:0] addr, logic [31:0] data);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 0;
            repeat (g)
                @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, data, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_access(kind, addr, data);
        @(negedge clk);
    endtask

    task automatic write_cfg(dmc_pkg::cfg_index_t idx, bit val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == dmc_pkg::CFG_WRITE_THROUGH)
            sb.wt = val;
        else
            sb.nwa = val;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic drain();
        int n;
        s_tvalid <= 0;
        n = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        while (n < 40)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    task automatic set_policy(bit wt, bit nwa);
        drain();
        write_cfg(dmc_pkg::CFG_WRITE_THROUGH, wt);
        write_cfg(dmc_pkg::CFG_NO_WRITE_ALLOCATE, nwa);
    endtask

    task automatic random_phase(int n);
        logic [11:0] a;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                a = 12'($urandom_range(0, 4095));
            else
                a = {2'b00, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 7)),
                     2'($urandom_range(0, 3))};
            if ($urandom_range(0, 3) == 0)
                a = {2'($urandom_range(0, 3)), a[9:0]};
            send_access(dmc_pkg::access_t'($urandom_range(0, 1)), a, $urandom());
        end
    endtask

    initial
    begin
        sb        = new();
        cycles    = 0;
        hold_off  = 0;
        finished  = 0;
        rst_n     = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tuser   = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        set_policy(0, 0);
        send_access(dmc_pkg::ACC_READ,  12'h000, 32'h0);
        send_access(dmc_pkg::ACC_WRITE, 12'h000, 32'hFFFFFFFF);
        send_access(dmc_pkg::ACC_READ,  12'h000, 32'h0);
        send_access(dmc_pkg::ACC_WRITE, 12'h100, 32'h80000000);
        send_access(dmc_pkg::ACC_READ,  12'h000, 32'h0);
        send_access(dmc_pkg::ACC_WRITE, 12'hFFF, 32'h7FFFFFFF);
        send_access(dmc_pkg::ACC_READ,  12'hEFF, 32'h0);
        send_access(dmc_pkg::ACC_READ,  12'hFFF, 32'h0);
        set_policy(1, 0);
        send_access(dmc_pkg::ACC_WRITE, 12'h000, 32'h12345678);
        send_access(dmc_pkg::ACC_WRITE, 12'h204, 32'hA5A5A5A5);
        send_access(dmc_pkg::ACC_READ,  12'h104, 32'h0);
        send_access(dmc_pkg::ACC_READ,  12'h004, 32'h0);
        set_policy(1, 1);
        send_access(dmc_pkg::ACC_WRITE, 12'h308, 32'h5A5A5A5A);
        send_access(dmc_pkg::ACC_READ,  12'h308, 32'h0);
        set_policy(0, 1);
        send_access(dmc_pkg::ACC_WRITE, 12'h40C, 32'hDEADBEEF);
        send_access(dmc_pkg::ACC_READ,  12'h40C, 32'h0);
        send_access(dmc_pkg::ACC_WRITE, 12'h40C, 32'h1);
        send_access(dmc_pkg::ACC_READ,  12'h80C, 32'h0);
        send_access(dmc_pkg::ACC_READ,  12'h40C, 32'h0);

        hold_off = 300;
        random_phase(30);
        for (int ph = 0; ph < 8; ph++)
        begin
            set_policy(ph[0], ph[1]);
            random_phase(120);
        end

        drain();
        finished = 1;
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
